// ===== src/tpps_pkg.sv =====
// Package: shared types and constants for the timed point path smoother.
package tpps_pkg;

  localparam int unsigned FuturePointsDefault = 2;
  localparam logic [31:0] MoveEpsilonReset = 32'd66;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned InW = 168;
  localparam int unsigned OutW = 104;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_ADV = 2'd1,
    MODE_CLR = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  typedef struct packed {
    logic [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic fl;
  } point_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ADV_STEP,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_ADD_SHIFT,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [FracW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== src/tpps_div.sv =====
// Bit-serial restoring divider: floor((num << 16) / den), one quotient bit per cycle.
module tpps_div (
  input  logic                clk,
  input  logic                rst,
  input  tpps_pkg::div_req_t  req,
  output tpps_pkg::div_rsp_t  rsp
);

  localparam int unsigned CntW = $clog2(tpps_pkg::FracW + 1);

  logic [32:0] rem;
  logic [32:0] rem_next;
  logic [31:0] den;
  logic [tpps_pkg::FracW-1:0] quo;
  logic [CntW-1:0] cnt;
  logic busy;
  logic done;
  logic [32:0] trial;

  // num < den is guaranteed, so the integer quotient bits are all zero
  always_comb begin
    trial = {rem[31:0], 1'b0} - {1'b0, den};
    rem_next = trial[32] ? {rem[31:0], 1'b0} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CntW'(tpps_pkg::FracW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {1'b0, req.num};
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[tpps_pkg::FracW-2:0], ~trial[32]};
    end
  end

  assign rsp = {done, quo};

  as_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without busy");
  as_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider restarted while busy");
  as_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.den != 32'd0) else $error("divider zero divisor");

endmodule

// ===== src/tpps_lerp.sv =====
// Shift-add lerp: past + round((now - past) * f / 65536), one frac bit per cycle of step.
module tpps_lerp (
  input  logic                               clk,
  input  logic                               start,
  input  logic                               step,
  input  logic [tpps_pkg::FracW-1:0]         frac,
  input  logic signed [tpps_pkg::CoordW-1:0] past_c,
  input  logic signed [tpps_pkg::CoordW-1:0] now_c,
  output logic signed [tpps_pkg::CoordW-1:0] result
);

  localparam int unsigned AccW = tpps_pkg::CoordW + 1 + tpps_pkg::FracW + 1;

  logic signed [tpps_pkg::CoordW:0] d;
  logic signed [AccW-1:0] acc;
  logic [tpps_pkg::FracW-1:0] f;
  logic signed [AccW-1:0] rounded;

  // acc accumulates d*f shifted: process f from MSB, acc = acc*2 + d*bit
  always_ff @(posedge clk) begin
    if (start) begin
      d <= {now_c[tpps_pkg::CoordW-1], now_c} - {past_c[tpps_pkg::CoordW-1], past_c};
      f <= frac;
      acc <= '0;
    end else if (step) begin
      acc <= (acc <<< 1) + (f[tpps_pkg::FracW-1] ? AccW'(d) : '0);
      f <= {f[tpps_pkg::FracW-2:0], 1'b0};
    end
  end

  always_comb begin
    rounded = acc + AccW'(signed'(33'sd32768));
    result = past_c + tpps_pkg::CoordW'(rounded >>> tpps_pkg::FracW);
  end

endmodule

// ===== src/timed_point_path_smoother.sv =====
// Top level: timed point path smoother with serial divider and serial interpolators.
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata: mode, point_time, point_x, point_y, point_z, point_on_floor, period
//  m_axis  | out | tdata: valid_res, pos_x, pos_y, pos_z, on_floor, moving
//  cfg     | in  | cfg_wr_en, cfg_wr_data: move_epsilon
// Interpolation runs the serial divider and then the shift-add interpolators; a forced-in add
// can interpolate twice, once for the forced-in point and once for the result.
// Without interpolation an item goes from evaluation straight to output; an add may first shift
// its point in, and an advance first moves along the path step by step (up to FUTURE_POINTS + 2 steps).
// Reset clears all point state and sets move_epsilon to 66.
// One item at a time; the result register holds until taken, a new item is accepted then.
module timed_point_path_smoother #(
  parameter int unsigned FUTURE_POINTS = tpps_pkg::FuturePointsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [tpps_pkg::InW-1:0] s_axis_tdata,  // mode, point_time, x, y, z, on_floor, period
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [tpps_pkg::OutW-1:0] m_axis_tdata, // valid_res, pos_x, pos_y, pos_z, on_floor, moving
  input  logic                     cfg_wr_en,
  input  logic [31:0]              cfg_wr_data
);

  localparam int unsigned IdxW = (FUTURE_POINTS > 1) ? $clog2(FUTURE_POINTS) : 1;
  localparam int unsigned IterW = $clog2(FUTURE_POINTS + 3);
  localparam int unsigned Last = FUTURE_POINTS - 1;
  localparam int unsigned LerpCycles = tpps_pkg::FracW;

  tpps_pkg::state_t state, state_next;

  logic [31:0] move_epsilon;
  tpps_pkg::point_t fut [FUTURE_POINTS];
  tpps_pkg::point_t past, now;
  logic [31:0] play_time;

  logic [1:0] mode;
  tpps_pkg::point_t pin;
  logic [31:0] period;

  logic [IterW-1:0] iter;
  logic [4:0] lcnt;
  logic mid_pending;   // evaluation is for forcing in an unused future point
  logic [31:0] mid_time;

  tpps_pkg::div_req_t dreq;
  tpps_pkg::div_rsp_t drsp;
  logic [tpps_pkg::FracW-1:0] frac;
  logic lerp_start;
  logic lerp_step;
  logic signed [31:0] lx, ly, lz;
  logic signed [31:0] ex, ey, ez;

  logic valid_st;
  logic accept;
  logic dup, in_past, force_in;
  logic [32:0] nt;
  logic [IdxW-1:0] j;
  logic j_found;
  logic [32:0] play_sum;
  logic interp;
  logic [31:0] dx, dy, dz;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign valid_st = past.t != 32'd0 && now.t != 32'd0;

  always_comb begin
    dup = fut[Last].t == pin.t && fut[Last].x == pin.x && fut[Last].y == pin.y
          && fut[Last].z == pin.z;
    in_past = pin.t <= now.t;
    force_in = valid_st && fut[0].t > now.t;
    nt = {1'b0, fut[0].t} - ({1'b0, now.t} - {1'b0, play_time});
    if (nt[32]) begin
      nt = {1'b0, ({1'b0, now.t} < {1'b0, play_time}) ? 32'hFFFF_FFFF : 32'd0};
    end
    j = '0;
    j_found = 1'b0;
    for (int i = FUTURE_POINTS - 1; i >= 0; i--) begin
      if (fut[i].t > now.t) begin
        j = IdxW'(i);
        j_found = 1'b1;
      end
    end
    play_sum = {1'b0, play_time} + {1'b0, period};
    interp = valid_st && !(play_time < past.t) && !(now.t <= past.t || play_time >= now.t);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tpps_pkg::ST_IDLE: if (accept) state_next = tpps_pkg::ST_UPDATE;
      tpps_pkg::ST_UPDATE: begin
        case (tpps_pkg::mode_t'(mode))
          tpps_pkg::MODE_ADD: begin
            if (dup || in_past || force_in) state_next = tpps_pkg::ST_EVAL;
            else state_next = tpps_pkg::ST_ADD_SHIFT;
          end
          tpps_pkg::MODE_ADV: state_next = tpps_pkg::ST_ADV_STEP;
          default: state_next = tpps_pkg::ST_EVAL;
        endcase
      end
      tpps_pkg::ST_ADV_STEP: begin
        if (period == 32'd0 || iter == IterW'(FUTURE_POINTS + 2) || !(play_time > now.t)
            || !j_found) state_next = tpps_pkg::ST_FINISH;
      end
      tpps_pkg::ST_FINISH: state_next = tpps_pkg::ST_EVAL;
      tpps_pkg::ST_EVAL: state_next = interp ? tpps_pkg::ST_DIV : tpps_pkg::ST_MUL;
      tpps_pkg::ST_DIV: if (drsp.done) state_next = tpps_pkg::ST_MUL;
      tpps_pkg::ST_MUL: begin
        if (!interp || lcnt == 5'd0) begin
          state_next = mid_pending ? tpps_pkg::ST_ADD_SHIFT : tpps_pkg::ST_OUT;
        end
      end
      tpps_pkg::ST_ADD_SHIFT: state_next = tpps_pkg::ST_EVAL;
      tpps_pkg::ST_OUT: if (m_axis_tready) state_next = tpps_pkg::ST_IDLE;
      default: state_next = tpps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = state == tpps_pkg::ST_IDLE;
    m_axis_tvalid = state == tpps_pkg::ST_OUT;
    dreq.start = state == tpps_pkg::ST_EVAL && interp;
    dreq.num = play_time - past.t;
    dreq.den = now.t - past.t;
    lerp_start = state == tpps_pkg::ST_DIV && drsp.done;
    lerp_step = state == tpps_pkg::ST_MUL && lcnt != 5'd0;
    frac = drsp.quo;
  end

  always_comb begin
    if (!valid_st) begin
      ex = '0; ey = '0; ez = '0;
    end else if (play_time < past.t) begin
      ex = past.x; ey = past.y; ez = past.z;
    end else if (!interp) begin
      ex = now.x; ey = now.y; ez = now.z;
    end else begin
      ex = lx; ey = ly; ez = lz;
    end
    dx = (past.x > now.x) ? 32'(past.x - now.x) : 32'(now.x - past.x);
    dy = (past.y > now.y) ? 32'(past.y - now.y) : 32'(now.y - past.y);
    dz = (past.z > now.z) ? 32'(past.z - now.z) : 32'(now.z - past.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpps_pkg::ST_IDLE;
      move_epsilon <= tpps_pkg::MoveEpsilonReset;
      for (int i = 0; i < FUTURE_POINTS; i++) fut[i] <= '0;
      past <= '0;
      now <= '0;
      play_time <= '0;
      mid_pending <= 1'b0;
      iter <= '0;
      lcnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) move_epsilon <= cfg_wr_data;
      case (state)
        tpps_pkg::ST_IDLE: begin
          iter <= '0;
          mid_pending <= 1'b0;
        end
        tpps_pkg::ST_UPDATE: begin
          if (tpps_pkg::mode_t'(mode) == tpps_pkg::MODE_CLR
              || (tpps_pkg::mode_t'(mode) == tpps_pkg::MODE_ADD && !dup && in_past)) begin
            for (int i = 0; i < FUTURE_POINTS; i++) fut[i] <= '0;
            past <= '0;
            now <= '0;
            play_time <= '0;
          end else if (tpps_pkg::mode_t'(mode) == tpps_pkg::MODE_ADD) begin
            if (!dup && force_in) begin
              mid_pending <= 1'b1;
              mid_time <= nt[31:0];
            end
          end else if (tpps_pkg::mode_t'(mode) == tpps_pkg::MODE_ADV && period != 32'd0) begin
            play_time <= play_sum[32] ? 32'hFFFF_FFFF : play_sum[31:0];
          end
        end
        tpps_pkg::ST_ADV_STEP: begin
          if (period != 32'd0 && iter != IterW'(FUTURE_POINTS + 2) && play_time > now.t) begin
            iter <= iter + 1'b1;
            past <= now;
            if (j_found) now <= fut[j];
            else play_time <= now.t;
          end
        end
        tpps_pkg::ST_FINISH: begin
          if (play_time < past.t) play_time <= past.t;
        end
        tpps_pkg::ST_DIV: lcnt <= 5'(LerpCycles);
        tpps_pkg::ST_MUL: if (lcnt != 5'd0) lcnt <= lcnt - 1'b1;
        tpps_pkg::ST_ADD_SHIFT: begin
          if (tpps_pkg::mode_t'(mode) == tpps_pkg::MODE_ADD) begin
            if (mid_pending) begin
              mid_pending <= 1'b0;
              play_time <= mid_time;
              past.t <= mid_time;
              past.x <= ex; past.y <= ey; past.z <= ez;
              now <= fut[0];
            end
            for (int i = 0; i < Last; i++) fut[i] <= fut[i + 1];
            fut[Last] <= pin;
            if ((mid_pending ? fut[0].t : now.t) == 32'd0) begin
              play_time <= pin.t;
              past <= pin;
              now <= pin;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= s_axis_tdata[1:0];
      pin.t <= s_axis_tdata[33:2];
      pin.x <= s_axis_tdata[65:34];
      pin.y <= s_axis_tdata[97:66];
      pin.z <= s_axis_tdata[129:98];
      pin.fl <= s_axis_tdata[130];
      period <= s_axis_tdata[162:131];
    end
    if (state == tpps_pkg::ST_MUL && !mid_pending) begin
      m_axis_tdata <= {
        5'b00000,
        (play_time >= past.t && play_time <= now.t && past.t < now.t
          && (dx > move_epsilon || dy > move_epsilon || dz > move_epsilon)),
        valid_st && past.fl && now.fl,
        ez, ey, ex, valid_st};
    end
  end

  tpps_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  tpps_lerp u_lerp_x (.clk(clk), .start(lerp_start), .step(lerp_step), .frac(frac),
                      .past_c(past.x), .now_c(now.x), .result(lx));
  tpps_lerp u_lerp_y (.clk(clk), .start(lerp_start), .step(lerp_step), .frac(frac),
                      .past_c(past.y), .now_c(now.y), .result(ly));
  tpps_lerp u_lerp_z (.clk(clk), .start(lerp_start), .step(lerp_step), .frac(frac),
                      .past_c(past.z), .now_c(now.z), .result(lz));

  as_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open while result pending");
  as_out_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  as_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= IterW'(FUTURE_POINTS + 2)) else $error("advance overran");

endmodule

// ===== test/testbench.sv =====
// Testbench for the timed point path smoother: predicts every result and compares them.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [4:0]  pad;
    logic        moving;
    logic        on_floor;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic        valid;
  } pos_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [tpps_pkg::InW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [tpps_pkg::OutW-1:0] m_axis_tdata;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  timed_point_path_smoother u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // path state mirror
  logic [31:0] eps;
  logic [31:0] fut_t [2];
  longint      fut_c [2][3];
  logic        fut_f [2];
  logic [31:0] past_t, now_t, play_t;
  longint      past_c [3];
  longint      now_c [3];
  logic        past_f, now_f;

  pos_t expected_pos [$];
  int   mismatches;
  int   items_sent;
  int   results_seen;
  int   hold_cycles;
  longint cycle_count;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic void clear_path();
    for (int i = 0; i < 2; i++) begin
      fut_t[i] = 0;
      fut_f[i] = 0;
      for (int k = 0; k < 3; k++) fut_c[i][k] = 0;
    end
    past_t = 0; now_t = 0; play_t = 0; past_f = 0; now_f = 0;
    for (int k = 0; k < 3; k++) begin
      past_c[k] = 0;
      now_c[k] = 0;
    end
  endfunction

  function automatic longint floor_div16(longint q);
    if (q >= 0) return q / 65536;
    return -((-q + 65535) / 65536);
  endfunction

  function automatic bit interp_pos(output longint p [3]);
    longint num, den, f;
    if (past_t == 0 || now_t == 0) begin
      for (int k = 0; k < 3; k++) p[k] = 0;
      return 0;
    end
    if (play_t < past_t) begin
      for (int k = 0; k < 3; k++) p[k] = past_c[k];
      return 1;
    end
    if (now_t <= past_t || play_t >= now_t) begin
      for (int k = 0; k < 3; k++) p[k] = now_c[k];
      return 1;
    end
    num = longint'(play_t - past_t) << 16;
    den = longint'(now_t - past_t);
    f = num / den;
    for (int k = 0; k < 3; k++)
      p[k] = past_c[k] + floor_div16((now_c[k] - past_c[k]) * f + 32768);
    return 1;
  endfunction

  function automatic bit apart(longint a, longint b);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d > longint'(eps);
  endfunction

  function automatic void add_point(logic [31:0] t, longint c [3], logic fl);
    longint mid [3];
    longint nt;
    if (fut_t[1] == t && fut_c[1][0] == c[0] && fut_c[1][1] == c[1] && fut_c[1][2] == c[2])
      return;
    if (t <= now_t) begin
      clear_path();
      return;
    end
    if (past_t != 0 && now_t != 0 && fut_t[0] > now_t) begin
      nt = longint'(fut_t[0]) - (longint'(now_t) - longint'(play_t));
      if (nt < 0) nt = 0;
      if (nt > 64'hFFFF_FFFF) nt = 64'hFFFF_FFFF;
      void'(interp_pos(mid));
      play_t = nt[31:0];
      past_t = nt[31:0];
      for (int k = 0; k < 3; k++) past_c[k] = mid[k];
      now_t = fut_t[0];
      for (int k = 0; k < 3; k++) now_c[k] = fut_c[0][k];
      now_f = fut_f[0];
    end
    fut_t[0] = fut_t[1];
    fut_f[0] = fut_f[1];
    for (int k = 0; k < 3; k++) fut_c[0][k] = fut_c[1][k];
    fut_t[1] = t;
    fut_f[1] = fl;
    for (int k = 0; k < 3; k++) fut_c[1][k] = c[k];
    if (now_t == 0) begin
      play_t = t; past_t = t; now_t = t; past_f = fl; now_f = fl;
      for (int k = 0; k < 3; k++) begin
        past_c[k] = c[k];
        now_c[k] = c[k];
      end
    end
  endfunction

  function automatic void advance_play(logic [31:0] period);
    longint s;
    int j;
    if (period == 0) return;
    s = longint'(play_t) + longint'(period);
    play_t = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    for (int it = 0; it < 4 && play_t > now_t; it++) begin
      j = -1;
      past_t = now_t;
      past_f = now_f;
      for (int k = 0; k < 3; k++) past_c[k] = now_c[k];
      for (int i = 1; i >= 0; i--) if (fut_t[i] > now_t) j = i;
      if (j < 0) begin
        play_t = now_t;
        break;
      end
      now_t = fut_t[j];
      now_f = fut_f[j];
      for (int k = 0; k < 3; k++) now_c[k] = fut_c[j][k];
    end
    if (play_t < past_t) play_t = past_t;
  endfunction

  function automatic pos_t predict_pos(logic [tpps_pkg::InW-1:0] d);
    tpps_pkg::mode_t m;
    longint c [3];
    longint p [3];
    pos_t r;
    bit v;
    m = tpps_pkg::mode_t'(d[1:0]);
    if (m == tpps_pkg::MODE_ADD) begin
      c[0] = longint'($signed(d[65:34]));
      c[1] = longint'($signed(d[97:66]));
      c[2] = longint'($signed(d[129:98]));
      add_point(d[33:2], c, d[130]);
    end else if (m == tpps_pkg::MODE_ADV) begin
      advance_play(d[162:131]);
    end else if (m == tpps_pkg::MODE_CLR) begin
      clear_path();
    end
    v = interp_pos(p);
    r.pad = '0;
    r.valid = v;
    r.x = p[0][31:0];
    r.y = p[1][31:0];
    r.z = p[2][31:0];
    r.on_floor = v && past_f && now_f;
    r.moving = play_t >= past_t && play_t <= now_t && past_t < now_t &&
      (apart(past_c[0], now_c[0]) || apart(past_c[1], now_c[1]) || apart(past_c[2], now_c[2]));
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    pos_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (expected_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_pos.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d: expected v%b x%h y%h z%h f%b m%b, got v%b x%h y%h z%h f%b m%b",
              results_seen, want.valid, want.x, want.y, want.z, want.on_floor, want.moving,
              got.valid, got.x, got.y, got.z, got.on_floor, got.moving);
        end
      end
    end
  end

  // receiver: own stall pattern, or a long hold-off
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 0;
      end else if (($urandom % 64) < 32) begin
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= (cycle_count % 7) > 2 || ($urandom % 4) == 0;
      end
    end
  end

  task automatic send_item(tpps_pkg::mode_t m, logic [31:0] t, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic fl, logic [31:0] period);
    logic [tpps_pkg::InW-1:0] d;
    d = {5'd0, period, fl, z, y, x, t, m};
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_pos.push_back(predict_pos(d));
    items_sent++;
    if (($urandom % 8) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (expected_pos.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_eps(logic [31:0] v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    eps = v;
  endtask

  task automatic send_point(logic [31:0] t, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic fl);
    send_item(tpps_pkg::MODE_ADD, t, x, y, z, fl, $urandom);
  endtask

  task automatic send_adv(logic [31:0] p);
    send_item(tpps_pkg::MODE_ADV, $urandom, $urandom, $urandom, $urandom, 1'($urandom), p);
  endtask

  task automatic test_directed();
    send_adv(32'h10000);
    send_point(32'h10000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1);
    send_point(32'h10000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
    send_point(32'h30000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_point(32'h50000, 32'h10000, 32'h20000, 32'h30000, 1'b1);
    send_point(32'h70000, 0, 0, 0, 1'b0);
    send_adv(0);
    send_adv(32'h8000);
    send_adv(32'h18000);
    send_item(tpps_pkg::MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, 32'hFFFF_FFFF);
    send_adv(32'hFFFF_FFFF);
    send_point(32'h20000, 1, 2, 3, 1'b1);
    send_point(0, 0, 0, 0, 1'b0);
    send_point(32'hFFFF_FFFE, 5, 5, 5, 1'b1);
    send_point(32'hFFFF_FFFF, 6, 6, 6, 1'b1);
    send_adv(32'hFFFF_FFFF);
    send_item(tpps_pkg::MODE_CLR, 0, 0, 0, 0, 1'b0, 0);
    send_point(32'h10, 100, 100, 100, 1'b1);
    send_point(32'h20, 150, 100, 100, 1'b1);
    send_adv(8);
    send_adv(3);
  endtask

  task automatic test_random(int count);
    logic [31:0] t;
    logic [31:0] x, y, z;
    int r;
    t = 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom % 100;
      x = (($urandom % 4) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      y = (($urandom % 4) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      z = (($urandom % 4) == 0) ? $urandom : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      if (r < 50) begin
        if (($urandom % 8) == 0 || t > 32'hF000_0000) t = $urandom_range(1, 32'h40000);
        else t = t + $urandom_range(1, 32'h30000);
        send_point(t, x, y, z, 1'($urandom));
      end else if (r < 53) begin
        send_point(fut_t[1], fut_c[1][0][31:0], fut_c[1][1][31:0], fut_c[1][2][31:0],
          1'($urandom));
      end else if (r < 56) begin
        send_point(($urandom % 2) ? $urandom : now_t, x, y, z, 1'($urandom));
      end else if (r < 90) begin
        send_adv((($urandom % 16) == 0) ? $urandom : $urandom_range(0, 32'h20000));
      end else if (r < 93) begin
        send_item(tpps_pkg::MODE_CLR, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
          $urandom);
        t = 0;
      end else if (r < 95) begin
        send_item(tpps_pkg::MODE_NOP, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
          $urandom);
      end else begin
        send_adv($urandom_range(1, 32'h8000));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int n = 0; n < 6; n++) send_adv($urandom_range(1, 32'h4000));
    test_random(30);
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    hold_cycles = 0;
    eps = tpps_pkg::MoveEpsilonReset;
    clear_path();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(250);
    write_eps(0);
    test_random(200);
    write_eps(32'hFFFF_FFFF);
    test_random(150);
    write_eps(32'h0001_0000);
    test_backpressure();
    test_random(280);
    drain();
    $display("Sent %0d items (adds, advances, clears, no-ops) over 4 epsilon settings,",
      items_sent);
    $display("checked %0d results, including a long output stall.", results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatch count: %0d", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
